### rtl/lbpf_pkg.sv
// ----------------------------------------------------------------------------
// lbpf_pkg
// Shared types and constants for the local binary pattern filter.
// ----------------------------------------------------------------------------
package lbpf_pkg;

  // line store geometry
  localparam int MAX_WIDTH = 4096;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);

  // field widths
  localparam int PIX_W  = 8;
  localparam int COL_W  = 12;
  localparam int ROW_W  = 16;
  localparam int IMGW_W = 13;

  // pattern modes
  localparam logic [1:0] MODE_STANDARD = 2'd0;
  localparam logic [1:0] MODE_MODIFIED = 2'd1;
  localparam logic [1:0] MODE_UNIFORM  = 2'd2;

  // register indexes
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_LARGE  = 2'd1;
  localparam logic [1:0] REG_WIDTH  = 2'd2;
  localparam logic [1:0] REG_HEIGHT = 2'd3;

  // register reset values and limits
  localparam logic [IMGW_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [ROW_W-1:0]  HEIGHT_RESET = 16'd480;
  localparam logic [IMGW_W-1:0] WIDTH_MIN    = 13'd5;
  localparam logic [IMGW_W-1:0] WIDTH_MAX    = IMGW_W'(MAX_WIDTH);
  localparam logic [ROW_W-1:0]  HEIGHT_MIN   = 16'd5;

  // code reported for a non-uniform pattern
  localparam logic [7:0] NON_UNIFORM_CODE = 8'd9;

  typedef logic [PIX_W-1:0] pixel_t;

  // 5x5 window, [row][column], row 4 / column 4 is the newest pixel
  typedef pixel_t [4:0][4:0] window_t;

  // code unit control
  typedef struct packed {
    logic modified;
    logic uniform;
    logic margin_two;
  } code_ctrl_t;

  // one buffered result
  typedef struct packed {
    logic [7:0]       code;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             last;
  } result_t;

endpackage

### rtl/lbpf_code.sv
// ----------------------------------------------------------------------------
// lbpf_code
// Pattern code for one window: ring select, threshold, uniformity check.
// ----------------------------------------------------------------------------
module lbpf_code
  import lbpf_pkg::*;
(
  input  window_t    win,
  input  code_ctrl_t ctrl,
  output logic [7:0] code
);

  pixel_t      g [8];
  pixel_t      centre;
  logic [10:0] sum;
  pixel_t      avg;
  logic [7:0]  bits;
  logic [7:0]  flips;
  logic [3:0]  trans;

  // neighbour select: far ring, mixed ring or 3x3 ring
  always_comb begin
    if (ctrl.modified) begin
      g[0] = win[0][0]; g[1] = win[0][2]; g[2] = win[0][4]; g[3] = win[2][4];
      g[4] = win[4][4]; g[5] = win[4][2]; g[6] = win[4][0]; g[7] = win[2][0];
    end else if (ctrl.margin_two) begin
      g[0] = win[1][1]; g[1] = win[0][2]; g[2] = win[1][3]; g[3] = win[2][4];
      g[4] = win[3][3]; g[5] = win[4][2]; g[6] = win[3][1]; g[7] = win[2][0];
    end else begin
      g[0] = win[2][2]; g[1] = win[2][3]; g[2] = win[2][4]; g[3] = win[3][4];
      g[4] = win[4][4]; g[5] = win[4][3]; g[6] = win[4][2]; g[7] = win[3][2];
    end
  end

  assign centre = ctrl.margin_two ? win[2][2] : win[3][3];

  // average of the ring: sum plus one, shifted right by three (truncated)
  always_comb begin
    sum = 11'd1;
    for (int p = 0; p < 8; p++) begin
      sum = sum + {3'b000, g[p]};
    end
  end

  assign avg = sum[10:3];

  // threshold bits
  always_comb begin
    for (int p = 0; p < 8; p++) begin
      bits[p] = ctrl.modified ? (g[p] > avg) : (g[p] >= centre);
    end
  end

  // circular transitions
  assign flips = bits ^ {bits[6:0], bits[7]};

  always_comb begin
    trans = 4'd0;
    for (int p = 0; p < 8; p++) begin
      trans = trans + {3'b000, flips[p]};
    end
  end

  assign code = (ctrl.uniform && (trans > 4'd2)) ? NON_UNIFORM_CODE : bits;

endmodule

### rtl/local_binary_pattern_filter.sv
// ----------------------------------------------------------------------------
// local_binary_pattern_filter
// Streaming local binary pattern filter with a four-row line store and a
// 5x5 window; one code per interior centre pixel.
// ----------------------------------------------------------------------------
//
//  channel   signals                                   direction
//  -------   ---------------------------------------   ---------
//  pixel     pixel_valid, pixel_ready, pixel           in
//  result    result_valid, result_ready, pattern_code,
//            centre_column, centre_row, frame_last     out
//  config    psel, penable, pwrite, paddr, pwdata,
//            prdata, pready                            in/out
//
//  One pixel per cycle while pixel_ready is high. A request reads the line
//  store at its column on acceptance; the next cycle shifts the window,
//  writes the column back and computes the code, which enters the result
//  buffer then. Reset clears the counters, the window and the buffer; the
//  line store is not cleared (row zero sees zeros above). The result buffer
//  holds four requests; pixel_ready drops when it could overflow.
//
module local_binary_pattern_filter
  import lbpf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // pixel channel
  input  logic              pixel_valid,
  output logic              pixel_ready,
  input  logic [PIX_W-1:0]  pixel,
  // result channel
  output logic              result_valid,
  input  logic              result_ready,
  output logic [7:0]        pattern_code,
  output logic [COL_W-1:0]  centre_column,
  output logic [ROW_W-1:0]  centre_row,
  output logic              frame_last,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // configuration registers
  logic [1:0]        pattern_mode;
  logic              large_kernel;
  logic [IMGW_W-1:0] image_width;
  logic [ROW_W-1:0]  image_height;

  // position counters
  logic [COL_W-1:0]  column_count;
  logic [ROW_W-1:0]  row_count;

  // second stage
  logic              s1_valid;
  pixel_t            s1_pix;
  logic [ADDR_W-1:0] s1_col;
  logic              s1_row_zero;
  logic              s1_has;
  logic [COL_W-1:0]  s1_ccol;
  logic [ROW_W-1:0]  s1_crow;
  logic              s1_last;

  // line store
  logic [31:0]       line_mem [MAX_WIDTH];
  logic [31:0]       line_rdata;
  logic [31:0]       upper;

  // window
  window_t           win;
  window_t           win_next;

  // result buffer
  result_t           buf_mem [4];
  logic [1:0]        wr_ptr;
  logic [1:0]        rd_ptr;
  logic [2:0]        buf_count;
  logic              push;
  logic              pop;

  logic              accept;
  logic [1:0]        mode_eff;
  logic              margin_two;
  code_ctrl_t        ctrl;
  logic [7:0]        code;

  logic [IMGW_W-1:0] eff_w;
  logic [ROW_W-1:0]  eff_h;
  logic [IMGW_W-1:0] col_plus;
  logic [ROW_W:0]    row_plus;
  logic              col_end;
  logic              row_end;
  logic              has_result;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_mode <= MODE_STANDARD;
      large_kernel <= 1'b0;
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_MODE:   pattern_mode <= pwdata[1:0];
        REG_LARGE:  large_kernel <= pwdata[0];
        REG_WIDTH:  image_width  <= pwdata[IMGW_W-1:0];
        REG_HEIGHT: image_height <= pwdata[ROW_W-1:0];
        default:    pattern_mode <= pattern_mode;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MODE:   prdata = {30'd0, pattern_mode};
      REG_LARGE:  prdata = {31'd0, large_kernel};
      REG_WIDTH:  prdata = {19'd0, image_width};
      REG_HEIGHT: prdata = {16'd0, image_height};
      default:    prdata = 32'd0;
    endcase
  end

  // unused mode code falls back to standard
  assign mode_eff   = (pattern_mode == MODE_MODIFIED || pattern_mode == MODE_UNIFORM)
                      ? pattern_mode : MODE_STANDARD;
  assign margin_two = (mode_eff == MODE_MODIFIED) || large_kernel;

  // clamped geometry
  always_comb begin
    if (image_width < WIDTH_MIN) begin
      eff_w = WIDTH_MIN;
    end else if (image_width > WIDTH_MAX) begin
      eff_w = WIDTH_MAX;
    end else begin
      eff_w = image_width;
    end
    eff_h = (image_height < HEIGHT_MIN) ? HEIGHT_MIN : image_height;
  end

  // ---------------------------------------------------------------- accept
  // buffer space counts the result that the second stage may still push
  assign pixel_ready = ({1'b0, buf_count} + {3'd0, s1_valid && s1_has}) < 4'd4;
  assign accept      = pixel_valid && pixel_ready;

  assign col_plus = {1'b0, column_count} + 13'd1;
  assign row_plus = {1'b0, row_count} + 17'd1;
  assign col_end  = col_plus >= eff_w;
  assign row_end  = row_plus >= {1'b0, eff_h};

  assign has_result = margin_two
                      ? (row_count >= 16'd4 && column_count >= 12'd4)
                      : (row_count >= 16'd2 && column_count >= 12'd2);

  // position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (col_end) begin
        column_count <= '0;
        row_count    <= row_end ? '0 : row_plus[ROW_W-1:0];
      end else begin
        column_count <= col_plus[COL_W-1:0];
      end
    end
  end

  // second stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  // second stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix      <= pixel;
      s1_col      <= column_count[ADDR_W-1:0];
      s1_row_zero <= (row_count == '0);
      s1_has      <= has_result;
      s1_ccol     <= column_count - (margin_two ? 12'd2 : 12'd1);
      s1_crow     <= row_count - (margin_two ? 16'd2 : 16'd1);
      s1_last     <= col_end && row_end;
    end
  end

  // ---------------------------------------------------------------- line store
  // read at acceptance, write back in the next cycle at a different column
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      line_mem[s1_col] <= {upper[23:0], s1_pix};
    end
    if (accept) begin
      line_rdata <= line_mem[column_count[ADDR_W-1:0]];
    end
  end

  assign upper = s1_row_zero ? 32'd0 : line_rdata;

  // ---------------------------------------------------------------- window
  always_comb begin
    for (int i = 0; i < 5; i++) begin
      for (int j = 0; j < 4; j++) begin
        win_next[i][j] = win[i][j+1];
      end
    end
    win_next[4][4] = s1_pix;
    win_next[3][4] = upper[7:0];
    win_next[2][4] = upper[15:8];
    win_next[1][4] = upper[23:16];
    win_next[0][4] = upper[31:24];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (s1_valid) begin
      win <= win_next;
    end
  end

  // code from the shifted window
  assign ctrl.modified   = (mode_eff == MODE_MODIFIED);
  assign ctrl.uniform    = (mode_eff == MODE_UNIFORM);
  assign ctrl.margin_two = margin_two;

  lbpf_code u_code (
    .win  (win_next),
    .ctrl (ctrl),
    .code (code)
  );

  // ---------------------------------------------------------------- result buffer
  assign push = s1_valid && s1_has;
  assign pop  = result_valid && result_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      buf_mem[wr_ptr] <= '{code: code, col: s1_ccol, row: s1_crow, last: s1_last};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      buf_count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 2'd1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      buf_count <= buf_count + {2'd0, push} - {2'd0, pop};
    end
  end

  assign result_valid  = (buf_count != '0);
  assign pattern_code  = buf_mem[rd_ptr].code;
  assign centre_column = buf_mem[rd_ptr].col;
  assign centre_row    = buf_mem[rd_ptr].row;
  assign frame_last    = buf_mem[rd_ptr].last;

endmodule
